[src/hes_pkg.sv]
// ----------------------------------------------------------------------------
// hes_pkg: shared constants for the Heston path stepper
// Fixed-point constants, register indexes and the Taylor divide tables.
// ----------------------------------------------------------------------------
package hes_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_INIT_VAR  = 3'd0,
      REG_KAPPA     = 3'd1,
      REG_THETA     = 3'd2,
      REG_XI        = 3'd3,
      REG_CORR      = 3'd4,
      REG_RATE      = 3'd5,
      REG_STEP_SIZE = 3'd6,
      REG_STRIKE    = 3'd7
   } csr_reg_type;

   typedef logic signed [32:0] mul_op_type;
   typedef logic signed [65:0] mul_prod_type;

   localparam logic [30:0]        ONE24     = 31'd16777216;
   localparam logic [30:0]        MAX31     = 31'h7FFF_FFFF;
   localparam logic [30:0]        ONE30     = 31'd1073741824;
   localparam logic [24:0]        LOG2E_Q24 = 25'd24204406;
   localparam logic [29:0]        LN2_Q30   = 30'd744261118;
   localparam logic signed [31:0] EXP_LIM   = 32'sd1073741824;
   localparam logic signed [25:0] RHO_MAX   = 26'sd16777216;
   localparam logic [48:0]        ONE48     = 49'h1_0000_0000_0000;
   localparam logic [3:0]         TAYLOR_N  = 4'd13;

   // ceil(2^s / n) with s = 30 + ceil(log2 n): exact floor(v / n) for v < 2^30
   function automatic logic [30:0] taylor_recip(input logic [3:0] n);
      logic [30:0] r;
      case (n)
         4'd3, 4'd6, 4'd12: r = 31'd1431655766;
         4'd5, 4'd10:       r = 31'd1717986919;
         4'd7:              r = 31'd1227133514;
         4'd9:              r = 31'd1908874354;
         4'd11:             r = 31'd1561806290;
         4'd13:             r = 31'd1321528399;
         default:           r = ONE30;
      endcase
      return r;
   endfunction

   function automatic logic [5:0] taylor_shift(input logic [3:0] n);
      logic [5:0] s;
      case (n)
         4'd1:              s = 6'd30;
         4'd2:              s = 6'd31;
         4'd3, 4'd4:        s = 6'd32;
         4'd5, 4'd6, 4'd7, 4'd8: s = 6'd33;
         default:           s = 6'd34;
      endcase
      return s;
   endfunction

endpackage

[src/heston_euler_path_step_top.sv]
// ----------------------------------------------------------------------------
// heston_euler_path_step_top: Heston Monte Carlo path stepper
// Full-truncation Euler on variance, log-Euler on price, one step per input.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one transaction is one time step, two Q4.12 standard normals.
//   rsp_*  : one transaction per finished path (every STEPS input
//            transactions): discounted call, discounted put, terminal price.
//   csr_*  : register writes; write only while idle, the block does not enforce it.
// Sequencing: a step runs through the sequencer states in turn; the last step of
//   a path also runs the discount and payoff states before its result is shown.
//   After any register write the next step first rebuilds the cached square roots.
//   The step time comes from one shared 33x33 multiplier, a bit-serial square
//   root and the exponential series to order 13, each term through T0, T1, T2.
// Throughput: one step in flight; req_tready is high only between steps.
// Reset: registers take their defaults, the path counter clears and the
//   next input starts a new path.
// Stall: a finished result waits in the output register; the next step is
//   accepted meanwhile and only the end of the following path waits on it.
// ----------------------------------------------------------------------------
module heston_euler_path_step_top
   import hes_pkg::*;
#(
   parameter int STEPS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [31:0]           req_tdata,   // normal_a, normal_b
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [95:0]           rsp_tdata,   // call_payoff, put_payoff, terminal_price
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam logic [CNT_W-1:0]   LAST_CNT = CNT_W'(STEPS - 1);
   localparam logic signed [13:0] STEPS_S  = 14'(STEPS);

   typedef enum logic [4:0] {
      ST_IDLE, ST_RHO2, ST_CSQ, ST_CWAIT, ST_DWAIT,
      ST_A0, ST_A1, ST_A2, ST_A3, ST_A4, ST_A5, ST_A6, ST_VWAIT,
      ST_B1, ST_B2, ST_B3, ST_B4, ST_B5, ST_B6,
      ST_E0, ST_E1, ST_E2, ST_E3, ST_T0, ST_T1, ST_T2,
      ST_P0, ST_P1, ST_D0, ST_FIN
   } state_type;

   // configuration
   logic [30:0]        init_var_ff, kappa_ff, theta_ff, xi_ff, dt_ff, strike_ff;
   logic signed [25:0] corr_ff;
   logic signed [31:0] rate_ff;

   // sequencer and path state
   state_type          state_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               cache_ok_ff;
   logic               phase_ff, half_ff;
   logic [30:0]        price_ff, var_ff;
   logic [15:0]        z1_ff, z2_ff;
   logic [24:0]        c_ff;
   logic [27:0]        sdt_ff;
   logic signed [55:0] acc_ff;
   logic signed [29:0] wv_ff;
   logic [30:0]        kd_ff, vol_ff, dx_ff;
   logic signed [41:0] x_ff;
   logic signed [39:0] rdt_ff;
   logic signed [31:0] ex_ff;
   logic signed [7:0]  k_ff;
   logic [23:0]        f_ff;
   logic [29:0]        t_ff;
   logic [30:0]        term_ff, m_ff;
   logic [3:0]         n_ff;
   logic [30:0]        pay_c_ff, pay_p_ff;
   logic               rsp_valid_ff;
   logic [95:0]        rsp_data_ff;

   // shared multiplier
   mul_op_type         mul_a, mul_b;
   mul_prod_type       prod_ff;

   // bit-serial square root
   logic               sq_start, sq_busy_ff;
   logic [55:0]        sq_arg, sq_rad_ff;
   logic [29:0]        sq_rem_ff;
   logic [27:0]        sq_root_ff;
   logic [4:0]         sq_cnt_ff;
   logic [31:0]        sq_rem2, sq_trial;

   logic signed [25:0] rho_c;
   logic signed [27:0] z1w, z2w;
   logic               last_step, req_acc;
   logic signed [8:0]  exp_sh;
   logic [61:0]        pm;
   logic [30:0]        scaled;
   logic [6:0]         left_amt;
   logic signed [55:0] vn;
   logic signed [53:0] disc_full;
   logic signed [54:0] disc_neg;
   logic [30:0]        term_next;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign last_step  = (cnt_ff == LAST_CNT);
   assign z1w        = {z1_ff, 12'b0};
   assign z2w        = {z2_ff, 12'b0};

   always_comb begin
      if (corr_ff > RHO_MAX) begin
         rho_c = RHO_MAX;
      end else if (corr_ff < -RHO_MAX) begin
         rho_c = -RHO_MAX;
      end else begin
         rho_c = corr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_var_ff <= '0;
         kappa_ff    <= '0;
         theta_ff    <= '0;
         xi_ff       <= '0;
         corr_ff     <= '0;
         rate_ff     <= '0;
         dt_ff       <= ONE24;
         strike_ff   <= ONE24;
      end else if (csr_we) begin
         case (csr_reg_type'(csr_index))
            REG_INIT_VAR:  init_var_ff <= csr_wdata[30:0];
            REG_KAPPA:     kappa_ff    <= csr_wdata[30:0];
            REG_THETA:     theta_ff    <= csr_wdata[30:0];
            REG_XI:        xi_ff       <= csr_wdata[30:0];
            REG_CORR:      corr_ff     <= csr_wdata[25:0];
            REG_RATE:      rate_ff     <= csr_wdata;
            REG_STEP_SIZE: dt_ff       <= csr_wdata[30:0];
            REG_STRIKE:    strike_ff   <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_RHO2:  begin mul_a = 33'(rho_c);  mul_b = 33'(rho_c); end
         ST_A0:    begin mul_a = 33'(rho_c);  mul_b = 33'(z1w); end
         ST_A1:    begin mul_a = 33'(c_ff);   mul_b = 33'(z2w); end
         ST_A2:    begin mul_a = 33'(kappa_ff); mul_b = 33'(dt_ff); end
         ST_A3:    begin
            mul_a = 33'(rate_ff) - 33'({3'b0, var_ff[30:1]});
            mul_b = 33'(dt_ff);
         end
         ST_A4:    begin mul_a = 33'(rate_ff); mul_b = 33'(dt_ff); end
         ST_A5:    begin
            mul_a = 33'(kd_ff);
            mul_b = 33'({2'b0, theta_ff}) - 33'({2'b0, var_ff});
         end
         ST_VWAIT: begin mul_a = 33'(sq_root_ff); mul_b = 33'(sdt_ff); end
         ST_B2:    begin mul_a = 33'(vol_ff); mul_b = 33'(z1w); end
         ST_B3:    begin mul_a = 33'(xi_ff);  mul_b = 33'(vol_ff); end
         ST_B5:    begin mul_a = 33'(dx_ff);  mul_b = 33'(wv_ff); end
         ST_E0:    begin mul_a = 33'(ex_ff);  mul_b = 33'(LOG2E_Q24); end
         ST_E2:    begin mul_a = 33'(f_ff);   mul_b = 33'(LN2_Q30); end
         ST_T0:    begin mul_a = 33'(term_ff); mul_b = 33'(t_ff); end
         ST_T1:    begin
            mul_a = 33'(prod_ff[59:30]);
            mul_b = 33'(taylor_recip(n_ff));
         end
         ST_P0:    begin
            mul_a = !phase_ff ? 33'(price_ff) : (half_ff ? 33'(pay_p_ff) : 33'(pay_c_ff));
            mul_b = 33'(m_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // square root, one result bit per cycle
   always_comb begin
      sq_start = 1'b0;
      sq_arg   = '0;
      case (state_ff)
         ST_CSQ:   begin sq_start = 1'b1; sq_arg = 56'(ONE48 - prod_ff[48:0]); end
         ST_CWAIT: begin sq_start = !sq_busy_ff; sq_arg = 56'({dt_ff, 24'b0}); end
         ST_A0:    begin sq_start = 1'b1; sq_arg = 56'({var_ff, 24'b0}); end
         default: ;
      endcase
      sq_rem2  = {sq_rem_ff, sq_rad_ff[55:54]};
      sq_trial = {2'b0, sq_root_ff, 2'b01};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_busy_ff <= 1'b0;
      end else if (sq_start) begin
         sq_busy_ff <= 1'b1;
         sq_rad_ff  <= sq_arg;
         sq_rem_ff  <= '0;
         sq_root_ff <= '0;
         sq_cnt_ff  <= 5'd27;
      end else if (sq_busy_ff) begin
         if (sq_rem2 >= sq_trial) begin
            sq_rem_ff  <= 30'(sq_rem2 - sq_trial);
            sq_root_ff <= {sq_root_ff[26:0], 1'b1};
         end else begin
            sq_rem_ff  <= sq_rem2[29:0];
            sq_root_ff <= {sq_root_ff[26:0], 1'b0};
         end
         sq_rad_ff <= {sq_rad_ff[53:0], 2'b00};
         sq_cnt_ff <= sq_cnt_ff - 5'd1;
         if (sq_cnt_ff == 5'd0) begin
            sq_busy_ff <= 1'b0;
         end
      end
   end

   // scale by 2^(k-30) with floor and saturation
   always_comb begin
      pm       = prod_ff[61:0];
      exp_sh   = 9'sd30 - 9'(k_ff);
      left_amt = 7'(-exp_sh);
      if (exp_sh >= 0) begin
         if ((pm >> 7'(exp_sh)) > 62'(MAX31)) begin
            scaled = MAX31;
         end else begin
            scaled = 31'(pm >> 7'(exp_sh));
         end
      end else if (left_amt >= 7'd31) begin
         scaled = (pm != '0) ? MAX31 : '0;
      end else if ((pm >> (7'd31 - left_amt)) != '0) begin
         scaled = MAX31;
      end else begin
         scaled = 31'(pm << left_amt);
      end
   end

   always_comb begin
      vn        = acc_ff + 56'(prod_ff >>> 24);
      disc_full = rdt_ff * STEPS_S;
      disc_neg  = -55'(disc_full);
      term_next = 31'(prod_ff[61:0] >> taylor_shift(n_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         cache_ok_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
         half_ff      <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            cache_ok_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_acc) begin
                  z1_ff <= req_tdata[15:0];
                  z2_ff <= req_tdata[31:16];
                  if (cnt_ff == '0) begin
                     price_ff <= ONE24;
                     var_ff   <= init_var_ff;
                  end
                  state_ff <= cache_ok_ff ? ST_A0 : ST_RHO2;
               end
            end
            ST_RHO2: state_ff <= ST_CSQ;
            ST_CSQ:  state_ff <= ST_CWAIT;
            ST_CWAIT: begin
               if (!sq_busy_ff) begin
                  c_ff     <= sq_root_ff[24:0];
                  state_ff <= ST_DWAIT;
               end
            end
            ST_DWAIT: begin
               if (!sq_busy_ff) begin
                  sdt_ff      <= sq_root_ff;
                  cache_ok_ff <= 1'b1;
                  state_ff    <= ST_A0;
               end
            end
            ST_A0: state_ff <= ST_A1;
            ST_A1: begin
               acc_ff   <= prod_ff[55:0];
               state_ff <= ST_A2;
            end
            ST_A2: begin
               wv_ff    <= 30'((acc_ff + prod_ff[55:0]) >>> 24);
               state_ff <= ST_A3;
            end
            ST_A3: begin
               kd_ff    <= (prod_ff[65:24] > 42'(MAX31)) ? MAX31 : prod_ff[54:24];
               state_ff <= ST_A4;
            end
            ST_A4: begin
               x_ff     <= 42'(prod_ff >>> 24);
               state_ff <= ST_A5;
            end
            ST_A5: begin
               rdt_ff   <= 40'(prod_ff >>> 24);
               state_ff <= ST_A6;
            end
            ST_A6: begin
               acc_ff   <= 56'({25'b0, var_ff}) + 56'(prod_ff >>> 24);
               state_ff <= ST_VWAIT;
            end
            ST_VWAIT: begin
               if (!sq_busy_ff) begin
                  state_ff <= ST_B1;
               end
            end
            ST_B1: begin
               vol_ff   <= prod_ff[54:24];
               state_ff <= ST_B2;
            end
            ST_B2: state_ff <= ST_B3;
            ST_B3: begin
               x_ff     <= x_ff + 42'(prod_ff >>> 24);
               state_ff <= ST_B4;
            end
            ST_B4: begin
               dx_ff    <= (prod_ff[65:24] > 42'(MAX31)) ? MAX31 : prod_ff[54:24];
               state_ff <= ST_B5;
            end
            ST_B5: state_ff <= ST_B6;
            ST_B6: begin
               if (vn < 0) begin
                  var_ff <= '0;
               end else if (vn > 56'(MAX31)) begin
                  var_ff <= MAX31;
               end else begin
                  var_ff <= vn[30:0];
               end
               if (x_ff > EXP_LIM) begin
                  ex_ff <= EXP_LIM;
               end else if (x_ff < -EXP_LIM) begin
                  ex_ff <= -EXP_LIM;
               end else begin
                  ex_ff <= 32'(x_ff);
               end
               phase_ff <= 1'b0;
               half_ff  <= 1'b0;
               state_ff <= ST_E0;
            end
            ST_E0: state_ff <= ST_E1;
            ST_E1: begin
               k_ff     <= prod_ff[55:48];
               f_ff     <= prod_ff[47:24];
               state_ff <= ST_E2;
            end
            ST_E2: state_ff <= ST_E3;
            ST_E3: begin
               t_ff     <= prod_ff[53:24];
               term_ff  <= ONE30;
               m_ff     <= ONE30;
               n_ff     <= 4'd1;
               state_ff <= ST_T0;
            end
            ST_T0: state_ff <= ST_T1;
            ST_T1: state_ff <= ST_T2;
            ST_T2: begin
               term_ff <= term_next;
               m_ff    <= m_ff + term_next;
               if (n_ff == TAYLOR_N) begin
                  state_ff <= ST_P0;
               end else begin
                  n_ff     <= n_ff + 4'd1;
                  state_ff <= ST_T0;
               end
            end
            ST_P0: state_ff <= ST_P1;
            ST_P1: begin
               if (!phase_ff) begin
                  price_ff <= scaled;
                  if (last_step) begin
                     state_ff <= ST_D0;
                  end else begin
                     cnt_ff   <= cnt_ff + CNT_W'(1);
                     state_ff <= ST_IDLE;
                  end
               end else if (!half_ff) begin
                  pay_c_ff <= scaled;
                  half_ff  <= 1'b1;
                  state_ff <= ST_P0;
               end else begin
                  pay_p_ff <= scaled;
                  state_ff <= ST_FIN;
               end
            end
            ST_D0: begin
               pay_c_ff <= (price_ff > strike_ff) ? price_ff - strike_ff : '0;
               pay_p_ff <= (strike_ff > price_ff) ? strike_ff - price_ff : '0;
               if (disc_neg > 55'(EXP_LIM)) begin
                  ex_ff <= EXP_LIM;
               end else if (disc_neg < -55'(EXP_LIM)) begin
                  ex_ff <= -EXP_LIM;
               end else begin
                  ex_ff <= 32'(disc_neg);
               end
               phase_ff <= 1'b1;
               half_ff  <= 1'b0;
               state_ff <= ST_E0;
            end
            ST_FIN: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {3'b0, price_ff, pay_p_ff, pay_c_ff};
                  cnt_ff       <= '0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_sqrt_free: assert property (@(posedge clock) disable iff (reset)
      sq_start |-> !sq_busy_ff)
      else $error("square root started while busy");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= LAST_CNT)
      else $error("step counter out of range");

   a_fin_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN) |-> last_step)
      else $error("result built before last step");

   a_accept_quiet: assert property (@(posedge clock) disable iff (reset)
      req_acc |-> !sq_busy_ff)
      else $error("step accepted while square root runs");

endmodule

[sim/heston_euler_path_step_top_tb.sv]
// ----------------------------------------------------------------------------
// heston_euler_path_step_top_tb: self-checking bench for the Heston stepper
// Streams normal pairs through several register settings, predicts each path
// result in fixed point and compares call, put and terminal price per result.
// ----------------------------------------------------------------------------
module heston_euler_path_step_top_tb;
   import hes_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     PATH_LEN  = 64;
   localparam longint Q_ONE24   = 64'sd16777216;
   localparam longint Q_ONE30   = 64'sd1073741824;
   localparam longint Q_MAX31   = 64'sd2147483647;
   localparam longint Q_LOG2E   = 64'sd24204406;
   localparam longint Q_LN2     = 64'sd744261118;
   localparam longint Q_EXP_LIM = 64'sd1073741824;
   localparam int     HOLD_AT   = 4;
   localparam int     HOLD_LEN  = 25000;

   typedef struct packed {
      logic [30:0] call_payoff;
      logic [30:0] put_payoff;
      logic [30:0] terminal_price;
   } payoff_type;

   typedef struct {
      logic [31:0] init_var, kappa, theta, xi, corr, rate, step_size, strike;
   } setting_type;

   typedef struct {
      logic [15:0] normal_a, normal_b;
   } draw_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = REG_INIT_VAR;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   payoff_type payoffs_due[$];
   int         mismatches = 0;
   int         steps_taken = 0;

   longint m_init_var, m_kappa, m_theta, m_xi, m_corr, m_rate, m_step_size, m_strike;
   longint m_price, m_var;
   int     m_step;

   heston_euler_path_step_top i_dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic longint isqrt(longint v);
      longint r, b;
      r = 0;
      b = longint'(1) << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint scale_by_exp(longint p, longint x);
      longint y, k, f, t, term, m, prod, sh, res;
      if (x > Q_EXP_LIM) x = Q_EXP_LIM;
      if (x < -Q_EXP_LIM) x = -Q_EXP_LIM;
      y = (x * Q_LOG2E) >>> 24;
      k = y >>> 24;
      f = y & (Q_ONE24 - 1);
      t = (f * Q_LN2) >>> 24;
      term = Q_ONE30;
      m = Q_ONE30;
      for (int n = 1; n <= 13; n++) begin
         term = ((term * t) >>> 30) / n;
         m = m + term;
      end
      prod = p * m;
      sh = 30 - k;
      if (sh >= 0) begin
         if (sh > 63) return 0;
         res = prod >>> sh;
      end else begin
         if (prod > (Q_MAX31 >>> (-sh))) return Q_MAX31;
         res = prod << (-sh);
      end
      return (res > Q_MAX31) ? Q_MAX31 : res;
   endfunction

   function automatic void model_write(csr_reg_type idx, logic [31:0] w);
      case (idx)
         REG_INIT_VAR:  m_init_var  = longint'(w[30:0]);
         REG_KAPPA:     m_kappa     = longint'(w[30:0]);
         REG_THETA:     m_theta     = longint'(w[30:0]);
         REG_XI:        m_xi        = longint'(w[30:0]);
         REG_CORR:      m_corr      = longint'($signed(w[25:0]));
         REG_RATE:      m_rate      = longint'($signed(w));
         REG_STEP_SIZE: m_step_size = longint'(w[30:0]);
         REG_STRIKE:    m_strike    = longint'(w[30:0]);
         default: ;
      endcase
   endfunction

   // advance one time step; returns 1 when the path ends
   function automatic bit euler_step(draw_type d, output payoff_type po);
      longint z1, z2, rho, c, wv, sdt, sv, vol, x, kd, dx, vn, disc, callv, putv;
      z1 = longint'($signed(d.normal_a)) * 4096;
      z2 = longint'($signed(d.normal_b)) * 4096;
      po = '0;
      if (m_step == 0) begin
         m_price = Q_ONE24;
         m_var = m_init_var;
      end
      rho = m_corr;
      if (rho > Q_ONE24) rho = Q_ONE24;
      if (rho < -Q_ONE24) rho = -Q_ONE24;
      c = isqrt((longint'(1) << 48) - rho * rho);
      wv = (rho * z1 + c * z2) >>> 24;
      sdt = isqrt(m_step_size << 24);
      sv = isqrt(m_var << 24);
      vol = (sv * sdt) >>> 24;
      x = (((m_rate - (m_var >>> 1)) * m_step_size) >>> 24) + ((vol * z1) >>> 24);
      m_price = scale_by_exp(m_price, x);
      kd = (m_kappa * m_step_size) >>> 24;
      if (kd > Q_MAX31) kd = Q_MAX31;
      dx = (m_xi * vol) >>> 24;
      if (dx > Q_MAX31) dx = Q_MAX31;
      vn = m_var + ((kd * (m_theta - m_var)) >>> 24) + ((dx * wv) >>> 24);
      if (vn < 0) vn = 0;
      if (vn > Q_MAX31) vn = Q_MAX31;
      m_var = vn;
      m_step++;
      if (m_step < PATH_LEN) return 0;
      disc = -(((m_rate * m_step_size) >>> 24) * PATH_LEN);
      callv = (m_price > m_strike) ? m_price - m_strike : 0;
      putv = (m_strike > m_price) ? m_strike - m_price : 0;
      po.call_payoff = 31'(scale_by_exp(callv, disc));
      po.put_payoff = 31'(scale_by_exp(putv, disc));
      po.terminal_price = 31'(m_price);
      m_step = 0;
      return 1;
   endfunction

   task automatic csr_write(csr_reg_type idx, logic [31:0] w);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= w;
      @(posedge clock);
      model_write(idx, w);
   endtask

   task automatic apply_setting(setting_type s);
      csr_write(REG_INIT_VAR, s.init_var);
      csr_write(REG_KAPPA, s.kappa);
      csr_write(REG_THETA, s.theta);
      csr_write(REG_XI, s.xi);
      csr_write(REG_CORR, s.corr);
      csr_write(REG_RATE, s.rate);
      csr_write(REG_STEP_SIZE, s.step_size);
      csr_write(REG_STRIKE, s.strike);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain_outputs();
      while (payoffs_due.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic send_draw(draw_type d, bit typed_reset_result);
      payoff_type po;
      int gap;
      req_tvalid <= 1'b1;
      req_tdata <= {d.normal_b, d.normal_a};
      do @(posedge clock); while (!req_tready);
      steps_taken++;
      if (euler_step(d, po)) begin
         if (typed_reset_result)
            payoffs_due.push_back('{31'd0, 31'd0, ONE24});
         else
            payoffs_due.push_back(po);
      end
      case ($urandom_range(0, 19))
         0:       gap = $urandom_range(20, 100);
         1, 2, 3: gap = $urandom_range(1, 4);
         default: gap = 0;
      endcase
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic logic [15:0] rand_normal();
      case ($urandom_range(0, 9))
         0:       return 16'($urandom);
         1:       return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
         default: return 16'($urandom_range(0, 8192) + $urandom_range(0, 8192)
                             + $urandom_range(0, 8192) - 12288);
      endcase
   endfunction

   function automatic setting_type rand_setting();
      setting_type s;
      if ($urandom_range(0, 3) == 0) begin
         s = '{32'($urandom) >> 1, 32'($urandom) >> 1, 32'($urandom) >> 1,
               32'($urandom) >> 1, 32'($urandom) >> 6, 32'($urandom),
               32'($urandom) >> 1, 32'($urandom) >> 1};
      end else begin
         s.init_var  = $urandom_range(0, 8388608);
         s.kappa     = $urandom_range(0, 83886080);
         s.theta     = $urandom_range(0, 5033165);
         s.xi        = $urandom_range(0, 16777216);
         s.corr      = 32'($urandom_range(0, 33554432) - 16777216);
         s.rate      = 32'($urandom_range(0, 3355443) - 1677722);
         s.step_size = $urandom_range(65536, 1048576);
         s.strike    = $urandom_range(8388608, 25165824);
      end
      return s;
   endfunction

   initial begin
      draw_type    edge_draws[$];
      setting_type fixed_settings[$];
      edge_draws = '{
         '{16'h0000, 16'h0000}, '{16'h7FFF, 16'h7FFF}, '{16'h8000, 16'h8000},
         '{16'h7FFF, 16'h8000}, '{16'h8000, 16'h7FFF}, '{16'h0001, 16'hFFFF},
         '{16'hFFFF, 16'h0001}, '{16'h1000, 16'hF000}, '{16'hF000, 16'h1000},
         '{16'h5555, 16'hAAAA}, '{16'hAAAA, 16'h5555}, '{16'h3000, 16'h0000},
         '{16'h0000, 16'hD000}, '{16'hFFFF, 16'hFFFF}, '{16'h0800, 16'h0800},
         '{16'h8001, 16'h7FFE}
      };
      fixed_settings = '{
         '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h01FFFFFF,
           32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF},
         '{32'd0, 32'd0, 32'd0, 32'd0, 32'hFE000000, 32'h80000000, 32'd1, 32'd0},
         '{32'd671089, 32'd33554432, 32'd671089, 32'd8388608, -32'sd11744051,
           32'd838861, 32'd0, 32'd16777216},
         '{32'd671089, 32'd25165824, 32'd671089, 32'd5033165, -32'sd11744051,
           32'd503316, 32'd262144, 32'd16777216},
         '{32'd8388608, 32'd50331648, 32'd3355443, 32'd33554432, 32'd16777216,
           32'd1677722, 32'd1048576, 32'd13421773},
         '{32'd8388608, 32'd50331648, 32'd3355443, 32'd33554432, -32'sd16777216,
           -32'sd8388608, 32'd1048576, 32'd13421773},
         '{32'd671089, 32'd16777216, 32'd671089, 32'd8388608, 32'd0,
           32'h64000000, 32'd16777216, 32'd8388608},
         '{32'd671089, 32'd16777216, 32'd671089, 32'd8388608, 32'd0,
           32'h9C000000, 32'd16777216, 32'd25165824}
      };
      m_init_var = 0; m_kappa = 0; m_theta = 0; m_xi = 0; m_corr = 0; m_rate = 0;
      m_step_size = Q_ONE24; m_strike = Q_ONE24;
      m_price = Q_ONE24; m_var = 0; m_step = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset defaults hold the price at one: no payoff at the money
      foreach (edge_draws[i]) send_draw(edge_draws[i], 1'b1);
      for (int i = edge_draws.size(); i < 3 * PATH_LEN; i++)
         send_draw('{rand_normal(), rand_normal()}, 1'b1);
      req_tvalid <= 1'b0;
      drain_outputs();

      foreach (fixed_settings[i]) begin
         apply_setting(fixed_settings[i]);
         repeat (2 * PATH_LEN) send_draw('{rand_normal(), rand_normal()}, 1'b0);
         req_tvalid <= 1'b0;
         drain_outputs();
      end
      repeat (6) begin
         apply_setting(rand_setting());
         repeat (PATH_LEN) send_draw('{rand_normal(), rand_normal()}, 1'b0);
         req_tvalid <= 1'b0;
         drain_outputs();
      end
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      int ready_pct;
      bit held;
      ready_pct = 100;
      held = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!held && steps_taken >= HOLD_AT) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_LEN) @(posedge clock);
         end else if ($urandom_range(0, 499) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(50, 400)) @(posedge clock);
         end else begin
            if ($urandom_range(0, 199) == 0) begin
               case ($urandom_range(0, 2))
                  0:       ready_pct = 100;
                  1:       ready_pct = 80;
                  default: ready_pct = 40;
               endcase
            end
            rsp_tready <= ($urandom_range(0, 99) < ready_pct);
         end
      end
   end

   always @(posedge clock) begin
      payoff_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata[30:0], rsp_tdata[61:31], rsp_tdata[92:62]};
         if (payoffs_due.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected transaction, actual %h", $time, got);
         end else begin
            want = payoffs_due.pop_front();
            if (got.call_payoff !== want.call_payoff) begin
               mismatches++;
               $display("%0t: call_payoff expected %0d actual %0d", $time,
                        want.call_payoff, got.call_payoff);
            end
            if (got.put_payoff !== want.put_payoff) begin
               mismatches++;
               $display("%0t: put_payoff expected %0d actual %0d", $time,
                        want.put_payoff, got.put_payoff);
            end
            if (got.terminal_price !== want.terminal_price) begin
               mismatches++;
               $display("%0t: terminal_price expected %0d actual %0d", $time,
                        want.terminal_price, got.terminal_price);
            end
         end
      end
   end

   initial begin
      #30ms;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
